// ===== rtl/hsv2rgb_pkg.sv =====
// shared constants, types and helpers for the hsv to rgb converter
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 8;
    localparam int UNIT_W    = FRAC_BITS + 1;

    // hue offset: a multiple of 360 that lifts every 16-bit hue above zero
    localparam int HUE_OFFSET = 33120;
    localparam int HUE_X_W    = 17;
    // floor(x / 360) as (x * HUE_RECIP) >> HUE_SHIFT, exact for x < 2^17
    localparam int HUE_SHIFT  = 25;
    localparam int HUE_RECIP  = (2 ** HUE_SHIFT + 359) / 360;
    localparam int HUE_PROD_W = 34;

    // f = floor(hm * ONE / 60) as (hm * F_RECIP) >> F_SHIFT, exact for hm < 60
    localparam int F_SHIFT    = 12;
    localparam int F_RECIP_W  = FRAC_BITS + 7;
    localparam int F_RECIP    = (2 ** (FRAC_BITS + F_SHIFT) + 59) / 60;
    localparam int F_PROD_W   = F_RECIP_W + 6;

    localparam int MUL_W      = 2 * FRAC_BITS + 2;
    localparam int CHAN_W     = FRAC_BITS + 9;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    localparam logic [FRAC_BITS:0] ONE = UNIT_W'(1) << FRAC_BITS;

    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [FRAC_BITS:0]   t_unit;
    typedef logic [2:0]           t_sector;
    typedef logic [7:0]           t_chan;

    // clamp a signed q1.8 word to 0..256 and rescale to the internal fraction
    function automatic t_unit clamp_unit(input logic signed [9:0] raw);
        logic [8:0]           c;
        logic [FRAC_BITS+8:0] w;
        if (raw < 10'sd0) begin
            c = 9'd0;
        end else if (raw > 10'sd256) begin
            c = 9'd256;
        end else begin
            c = raw[8:0];
        end
        w = {c, {FRAC_BITS{1'b0}}} >> 8;
        return w[FRAC_BITS:0];
    endfunction

endpackage

// ===== rtl/hsv2rgb_hue.sv =====
// hue reduction pipeline: modulo 360, sector and in-sector fraction
module hsv2rgb_hue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [15:0]      i_hue,
    input  logic signed [9:0]       i_saturation,
    input  logic signed [9:0]       i_brightness,
    output logic                    o_vld,
    output hsv2rgb_pkg::t_sector    o_sector,
    output hsv2rgb_pkg::t_frac      o_f,
    output hsv2rgb_pkg::t_unit      o_s,
    output hsv2rgb_pkg::t_unit      o_v
);
    import hsv2rgb_pkg::*;

    logic [4:0]          r_vld;
    t_unit               r_s [5];
    t_unit               r_v [5];
    logic [HUE_X_W-1:0]  r_x1;
    logic [HUE_X_W-1:0]  r_x2;
    logic [7:0]          r_q2;
    logic [8:0]          r_rem3;
    t_sector             r_sec4;
    logic [5:0]          r_hm4;
    t_sector             r_sec5;
    t_frac               r_f5;

    logic signed [17:0]  n_x;
    logic [HUE_PROD_W-1:0] n_qprod;
    logic [HUE_X_W-1:0]  n_rem;
    t_sector             n_sec;
    logic [8:0]          n_base;
    logic [F_PROD_W-1:0] n_fprod;

    always_comb begin
        n_x     = $signed({{2{i_hue[15]}}, i_hue}) + $signed(18'(HUE_OFFSET));
        n_qprod = HUE_PROD_W'(r_x1) * HUE_PROD_W'(HUE_RECIP);
        n_rem   = r_x2 - HUE_X_W'(r_q2) * HUE_X_W'(360);
        if (r_rem3 >= 9'd300) begin
            n_sec = SEC_5;
        end else if (r_rem3 >= 9'd240) begin
            n_sec = SEC_4;
        end else if (r_rem3 >= 9'd180) begin
            n_sec = SEC_3;
        end else if (r_rem3 >= 9'd120) begin
            n_sec = SEC_2;
        end else if (r_rem3 >= 9'd60) begin
            n_sec = SEC_1;
        end else begin
            n_sec = SEC_0;
        end
        case (n_sec)
            SEC_1:   n_base = 9'd60;
            SEC_2:   n_base = 9'd120;
            SEC_3:   n_base = 9'd180;
            SEC_4:   n_base = 9'd240;
            SEC_5:   n_base = 9'd300;
            default: n_base = 9'd0;
        endcase
        n_fprod = F_PROD_W'(r_hm4) * F_PROD_W'(F_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= clamp_unit(i_saturation);
            r_v[0] <= clamp_unit(i_brightness);
            for (int i = 1; i < 5; i++) begin
                r_s[i] <= r_s[i-1];
                r_v[i] <= r_v[i-1];
            end
            r_x1   <= n_x[HUE_X_W-1:0];
            r_x2   <= r_x1;
            r_q2   <= n_qprod[HUE_SHIFT+7:HUE_SHIFT];
            r_rem3 <= n_rem[8:0];
            r_sec4 <= n_sec;
            r_hm4  <= 6'(r_rem3 - n_base);
            r_sec5 <= r_sec4;
            r_f5   <= n_fprod[FRAC_BITS+F_SHIFT-1:F_SHIFT];
        end
    end

    assign o_vld    = r_vld[4];
    assign o_sector = r_sec5;
    assign o_f      = r_f5;
    assign o_s      = r_s[4];
    assign o_v      = r_v[4];

endmodule

// ===== rtl/hsv2rgb_pqt.sv =====
// p, q and t products over two register stages
module hsv2rgb_pqt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  hsv2rgb_pkg::t_sector    i_sector,
    input  hsv2rgb_pkg::t_frac      i_f,
    input  hsv2rgb_pkg::t_unit      i_s,
    input  hsv2rgb_pkg::t_unit      i_v,
    output logic                    o_vld,
    output hsv2rgb_pkg::t_sector    o_sector,
    output hsv2rgb_pkg::t_unit      o_p,
    output hsv2rgb_pkg::t_unit      o_q,
    output hsv2rgb_pkg::t_unit      o_t,
    output hsv2rgb_pkg::t_unit      o_v
);
    import hsv2rgb_pkg::*;

    logic [1:0]       r_vld;
    t_sector          r_sec [2];
    t_unit            r_v [2];
    t_unit            r_sf;
    t_unit            r_snf;
    t_unit            r_nps;
    t_unit            r_p;
    t_unit            r_q;
    t_unit            r_t;

    logic [MUL_W-1:0] n_sf;
    logic [MUL_W-1:0] n_snf;
    logic [MUL_W-1:0] n_p;
    logic [MUL_W-1:0] n_q;
    logic [MUL_W-1:0] n_t;

    always_comb begin
        n_sf  = MUL_W'(i_s) * MUL_W'(i_f);
        n_snf = MUL_W'(i_s) * MUL_W'(ONE - UNIT_W'(i_f));
        n_p   = MUL_W'(r_v[0]) * MUL_W'(r_nps);
        n_q   = MUL_W'(r_v[0]) * MUL_W'(ONE - r_sf);
        n_t   = MUL_W'(r_v[0]) * MUL_W'(ONE - r_snf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec[0] <= i_sector;
            r_sec[1] <= r_sec[0];
            r_v[0]   <= i_v;
            r_v[1]   <= r_v[0];
            r_sf     <= n_sf[2*FRAC_BITS:FRAC_BITS];
            r_snf    <= n_snf[2*FRAC_BITS:FRAC_BITS];
            r_nps    <= ONE - i_s;
            r_p      <= n_p[2*FRAC_BITS:FRAC_BITS];
            r_q      <= n_q[2*FRAC_BITS:FRAC_BITS];
            r_t      <= n_t[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_vld    = r_vld[1];
    assign o_sector = r_sec[1];
    assign o_p      = r_p;
    assign o_q      = r_q;
    assign o_t      = r_t;
    assign o_v      = r_v[1];

endmodule

// ===== rtl/hsv2rgb_mix.sv =====
// channel order per sector, scaling to 8 bits and the output register
module hsv2rgb_mix (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  hsv2rgb_pkg::t_sector    i_sector,
    input  hsv2rgb_pkg::t_unit      i_p,
    input  hsv2rgb_pkg::t_unit      i_q,
    input  hsv2rgb_pkg::t_unit      i_t,
    input  hsv2rgb_pkg::t_unit      i_v,
    output logic                    o_vld,
    output hsv2rgb_pkg::t_chan      o_red,
    output hsv2rgb_pkg::t_chan      o_green,
    output hsv2rgb_pkg::t_chan      o_blue
);
    import hsv2rgb_pkg::*;

    logic              r_vld;
    t_chan             r_red;
    t_chan             r_green;
    t_chan             r_blue;

    t_unit             n_r;
    t_unit             n_g;
    t_unit             n_b;
    logic [CHAN_W-1:0] n_rs;
    logic [CHAN_W-1:0] n_gs;
    logic [CHAN_W-1:0] n_bs;

    always_comb begin
        case (i_sector)
            SEC_1: begin
                n_r = i_q; n_g = i_v; n_b = i_p;
            end
            SEC_2: begin
                n_r = i_p; n_g = i_v; n_b = i_t;
            end
            SEC_3: begin
                n_r = i_p; n_g = i_q; n_b = i_v;
            end
            SEC_4: begin
                n_r = i_t; n_g = i_p; n_b = i_v;
            end
            SEC_5: begin
                n_r = i_v; n_g = i_p; n_b = i_q;
            end
            default: begin
                n_r = i_v; n_g = i_t; n_b = i_p;
            end
        endcase
        // x * 255 as a shift and subtract
        n_rs = (CHAN_W'(n_r) << 8) - CHAN_W'(n_r);
        n_gs = (CHAN_W'(n_g) << 8) - CHAN_W'(n_g);
        n_bs = (CHAN_W'(n_b) << 8) - CHAN_W'(n_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_rs[FRAC_BITS+7:FRAC_BITS];
            r_green <= n_gs[FRAC_BITS+7:FRAC_BITS];
            r_blue  <= n_bs[FRAC_BITS+7:FRAC_BITS];
        end
    end

    assign o_vld   = r_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// Converts one HSV colour word to 8-bit RGB per cycle. Hue is any signed
// 16-bit degree value and is reduced modulo 360; saturation and brightness
// are signed q1.8 and clamped to 0..1.0. Every word passes from input
// acceptance to the output register through the hue reduction and sector
// fraction stages, the p, q, t product stages and the channel scaling stage.
// A new word is taken every cycle; the whole pipeline holds while a finished
// word waits at the output, so input ready follows output ready.
module hsv_to_rgb_converter_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [15:0]      i_hue,
    input  logic signed [9:0]       i_saturation,
    input  logic signed [9:0]       i_brightness,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output hsv2rgb_pkg::t_chan      o_red,
    output hsv2rgb_pkg::t_chan      o_green,
    output hsv2rgb_pkg::t_chan      o_blue
);
    import hsv2rgb_pkg::*;

    logic    w_en;
    logic    w_hue_vld;
    t_sector w_hue_sec;
    t_frac   w_hue_f;
    t_unit   w_hue_s;
    t_unit   w_hue_v;
    logic    w_pqt_vld;
    t_sector w_pqt_sec;
    t_unit   w_p;
    t_unit   w_q;
    t_unit   w_t;
    t_unit   w_v;

    // hold every stage while the output word is not taken
    assign w_en       = !(o_out_valid && !i_out_ready);
    assign o_in_ready = w_en;

    hsv2rgb_hue u_hue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (i_in_valid),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_vld        (w_hue_vld),
        .o_sector     (w_hue_sec),
        .o_f          (w_hue_f),
        .o_s          (w_hue_s),
        .o_v          (w_hue_v)
    );

    hsv2rgb_pqt u_pqt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_hue_vld),
        .i_sector (w_hue_sec),
        .i_f      (w_hue_f),
        .i_s      (w_hue_s),
        .i_v      (w_hue_v),
        .o_vld    (w_pqt_vld),
        .o_sector (w_pqt_sec),
        .o_p      (w_p),
        .o_q      (w_q),
        .o_t      (w_t),
        .o_v      (w_v)
    );

    hsv2rgb_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_pqt_vld),
        .i_sector (w_pqt_sec),
        .i_p      (w_p),
        .i_q      (w_q),
        .i_t      (w_t),
        .i_v      (w_v),
        .o_vld    (o_out_valid),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_pqt_vld && !w_hue_vld)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({w_hue_vld, w_pqt_vld, o_out_valid}))
        else $error("valid bits moved during a stall");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hue_vld |-> w_hue_sec <= SEC_5)
        else $error("sector out of range");

    a_pqt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pqt_vld |-> (w_p <= w_v) && (w_q <= w_v) && (w_t <= w_v))
        else $error("p, q or t above value");

endmodule

// ===== test/hsv_to_rgb_converter_top_test.sv =====
// testbench for the hsv to rgb converter: random bursts and stalls, checked against a predictor
`timescale 1ns / 100ps

module hsv_to_rgb_converter_top_test;

    import hsv2rgb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_PERIOD  = 1500;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic signed [15:0] hue;
        logic signed [9:0]  sat;
        logic signed [9:0]  bri;
        logic               drain_first;
    } t_hsv_word;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_MOSTLY, RX_COMB} t_rx_mode;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic signed [15:0] hue_in    = '0;
    logic signed [9:0]  sat_in    = '0;
    logic signed [9:0]  bri_in    = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    t_chan              red;
    t_chan              green;
    t_chan              blue;

    t_hsv_word   pending_words[$];
    t_rgb        expected_rgb_q[$];
    logic        word_taken     = 1'b0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 20;
    int          gap_left       = 0;
    int          hold_left      = 0;
    int          mode_left      = 0;
    t_rx_mode    rx_mode        = RX_FREE;

    hsv_to_rgb_converter_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_hue        (hue_in),
        .i_saturation (sat_in),
        .i_brightness (bri_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_rgb hsv_to_rgb(input logic signed [15:0] hue,
                                        input logic signed [9:0] sat,
                                        input logic signed [9:0] bri);
        longint  unit_one, s, v, f, p, q, t, r, g, b;
        int      deg, sat_c, bri_c;
        t_sector sector;
        t_rgb    res;
        unit_one = longint'(1) << FRAC_BITS;
        deg = int'(hue) % 360;
        if (deg < 0) begin
            deg += 360;
        end
        sat_c = int'(sat);
        bri_c = int'(bri);
        if (sat_c < 0) sat_c = 0;
        if (sat_c > 256) sat_c = 256;
        if (bri_c < 0) bri_c = 0;
        if (bri_c > 256) bri_c = 256;
        s = (longint'(sat_c) << FRAC_BITS) >> 8;
        v = (longint'(bri_c) << FRAC_BITS) >> 8;
        sector = t_sector'(deg / 60);
        f = (longint'(deg % 60) << FRAC_BITS) / 60;
        p = (v * (unit_one - s)) >> FRAC_BITS;
        q = (v * (unit_one - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
        t = (v * (unit_one - ((s * (unit_one - f)) >> FRAC_BITS))) >> FRAC_BITS;
        case (sector)
            SEC_1: begin
                r = q; g = v; b = p;
            end
            SEC_2: begin
                r = p; g = v; b = t;
            end
            SEC_3: begin
                r = p; g = q; b = v;
            end
            SEC_4: begin
                r = t; g = p; b = v;
            end
            SEC_5: begin
                r = v; g = p; b = q;
            end
            default: begin
                r = v; g = t; b = p;
            end
        endcase
        res.red   = t_chan'((r * 255) >> FRAC_BITS);
        res.green = t_chan'((g * 255) >> FRAC_BITS);
        res.blue  = t_chan'((b * 255) >> FRAC_BITS);
        return res;
    endfunction

    task automatic add_word(input int hue, input int sat, input int bri, input logic drain);
        t_hsv_word w;
        w.hue         = 16'(hue);
        w.sat         = 10'(sat);
        w.bri         = 10'(bri);
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // sender: bursts of words with random gaps, valid held until taken
    always @(negedge i_clk) begin
        logic      nxt_valid;
        t_hsv_word w;
        if (i_rst_n && (!in_valid || word_taken)) begin
            if (word_taken) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_rgb_q.size() != 0)) begin
                w = pending_words.pop_front();
                hue_in <= w.hue;
                sat_in <= w.sat;
                bri_in <= w.bri;
                nxt_valid = 1'b1;
            end
            in_valid <= nxt_valid;
        end
    end

    // receiver: changing stall pattern plus a periodic long hold-off
    always @(negedge i_clk) begin
        logic nxt_ready;
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (cycle_count % HOLD_PERIOD == HOLD_START) begin
            hold_left = HOLD_CYCLES;
            nxt_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   nxt_ready = 1'b1;
                RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
                RX_MOSTLY: nxt_ready = ($urandom_range(0, 3) != 0);
                default:   nxt_ready = (cycle_count[2:0] != 3'd5);
            endcase
        end
        out_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                expected_rgb_q.push_back(hsv_to_rgb(hue_in, sat_in, bri_in));
            end
            if (out_valid && out_ready) begin
                if (expected_rgb_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected word: r=%0d g=%0d b=%0d", red, green, blue);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_rgb_q.pop_front();
                    if (red !== want.red || green !== want.green || blue !== want.blue) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want.red, want.green, want.blue, red, green, blue);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int hue, sat, bri;
        // sector boundaries, wrap and clamp cases
        add_word(0, 256, 256, 1'b0);
        add_word(60, 256, 256, 1'b0);
        add_word(120, 256, 256, 1'b0);
        add_word(180, 256, 256, 1'b0);
        add_word(240, 256, 256, 1'b0);
        add_word(300, 256, 256, 1'b0);
        add_word(359, 256, 256, 1'b0);
        add_word(360, 256, 256, 1'b0);
        add_word(-1, 256, 256, 1'b0);
        add_word(-360, 256, 256, 1'b0);
        add_word(-32768, 256, 256, 1'b0);
        add_word(32767, 256, 256, 1'b0);
        add_word(59, 128, 200, 1'b0);
        add_word(30, -512, 511, 1'b0);
        add_word(90, 511, -512, 1'b0);
        add_word(150, 257, -1, 1'b0);
        add_word(210, 255, 255, 1'b0);
        add_word(270, 0, 0, 1'b0);
        add_word(330, -1, 256, 1'b0);
        add_word(45, 256, 1, 1'b0);
        add_word(-12345, 100, 511, 1'b0);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            case ($urandom_range(0, 3))
                0:       hue = int'($signed(16'($urandom)));
                1:       hue = $urandom_range(0, 359);
                2:       hue = 60 * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
                default: hue = -int'($urandom_range(1, 1080));
            endcase
            sat = ($urandom_range(0, 3) == 0) ? int'($signed(10'($urandom)))
                                              : $urandom_range(0, 256);
            bri = ($urandom_range(0, 3) == 0) ? int'($signed(10'($urandom)))
                                              : $urandom_range(0, 256);
            add_word(hue, sat, bri, (i == 0 || i == RANDOM_WORDS / 2));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_rgb_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && expected_rgb_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_hue.sv
rtl/hsv2rgb_pqt.sv
rtl/hsv2rgb_mix.sv
rtl/hsv_to_rgb_converter_top.sv
test/hsv_to_rgb_converter_top_test.sv
